@@ rtl/smx_pkg.sv @@
// Shared types and constants for the stack machine executor.
package smx_pkg;

   // Field widths fixed by the instruction format.
   localparam int KIND_W  = 4;
   localparam int WORD_W  = 32;
   localparam int LEN_W   = 16;
   localparam int DEPTH_W = 7;

   // Response queue geometry.
   localparam int QUEUE_DEPTH = 3;
   localparam int QPTR_W      = 2;
   localparam int QLVL_W      = 2;

   // Opcodes.
   localparam logic [KIND_W-1:0] OP_PUSH   = 4'd0;
   localparam logic [KIND_W-1:0] OP_POP    = 4'd1;
   localparam logic [KIND_W-1:0] OP_ADD    = 4'd2;
   localparam logic [KIND_W-1:0] OP_READ   = 4'd3;
   localparam logic [KIND_W-1:0] OP_WRITE  = 4'd4;
   localparam logic [KIND_W-1:0] OP_DUP    = 4'd5;
   localparam logic [KIND_W-1:0] OP_JUMPIF = 4'd6;
   localparam logic [KIND_W-1:0] OP_MUL    = 4'd7;
   localparam logic [KIND_W-1:0] OP_SWAP   = 4'd8;
   localparam logic [KIND_W-1:0] OP_OVER   = 4'd9;

   // Action decided at issue, carried out at execute.
   typedef enum logic [3:0] {
      ACT_NONE,
      ACT_PUSH_IMM,
      ACT_PUSH_RD,
      ACT_POP,
      ACT_ADD,
      ACT_MUL,
      ACT_WRITE,
      ACT_DUP,
      ACT_JUMP,
      ACT_SWAP,
      ACT_OVER
   } act_type;

   typedef struct packed {
      logic        [KIND_W-1:0] kind;
      logic signed [WORD_W-1:0] immediate;
      logic signed [WORD_W-1:0] read_value;
   } req_type;

   typedef struct packed {
      logic signed [WORD_W-1:0]  next_pc;
      logic                      halted;
      logic                      write_valid;
      logic signed [WORD_W-1:0]  write_value;
      logic                      overflow_flag;
      logic        [DEPTH_W-1:0] stack_depth;
   } rsp_type;

endpackage

@@ rtl/stack_machine_executor.sv @@
// Top level of the stack machine executor: request admission, core and response queue.
//
// Executes one stack-machine instruction per request and returns one response per request.
// A request can be accepted in every clock cycle while the queue has room. The cycle after
// acceptance is its execute cycle; at the end of that cycle its response enters the response
// queue and is offered from the next cycle. The top stack entry sits in a register and the
// rest of the stack in a RAM with one write port and one registered read port. The read of
// the second entry is issued in the acceptance cycle, so every instruction retires in its
// execute cycle; a value written to the RAM in a cycle is forwarded to the read issued in
// that cycle. Responses wait in a three-entry queue, and requests are held off only while
// that queue, together with the instruction in execute, is full. The stack RAM needs no
// clearing after reset. The program length register is written through csr_wr_en and
// csr_wr_data and must be written only while no request is outstanding.
module stack_machine_executor #(
   parameter int STACK_DEPTH = 64
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  smx_pkg::req_type            req_payload,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output smx_pkg::rsp_type            rsp_payload,
   input  logic                        csr_wr_en,
   input  logic [smx_pkg::LEN_W-1:0]   csr_wr_data
);
   import smx_pkg::*;

   logic [LEN_W-1:0]   program_length_ff, program_length_in;
   logic               req_fire;
   logic               exec_valid;
   rsp_type            exec_result;
   logic [QLVL_W-1:0]  level;
   logic [QLVL_W:0]    in_flight;

   // Program length register.
   assign program_length_in = csr_wr_en ? csr_wr_data : program_length_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         program_length_ff <= '0;
      end else begin
         program_length_ff <= program_length_in;
      end
   end

   // Admit a request only when its response is sure to find room in the queue.
   assign in_flight = {1'b0, level} + (QLVL_W + 1)'(exec_valid);
   assign req_ready = (in_flight < (QLVL_W + 1)'(QUEUE_DEPTH));
   assign req_fire  = req_valid && req_ready;

   smx_core #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_core (
      .clock          (clock),
      .reset          (reset),
      .req_fire       (req_fire),
      .req_payload    (req_payload),
      .program_length (program_length_ff),
      .exec_valid     (exec_valid),
      .exec_result    (exec_result)
   );

   smx_rsp_queue u_rsp_queue (
      .clock       (clock),
      .reset       (reset),
      .push        (exec_valid),
      .push_data   (exec_result),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .level       (level)
   );

endmodule

@@ rtl/smx_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
module smx_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port; a read of the address being written returns old data.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/smx_core.sv @@
// Instruction core: issue stage with the stack RAM read, execute stage with the top-of-stack register.
module smx_core #(
   parameter int STACK_DEPTH = 64
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_fire,
   input  smx_pkg::req_type            req_payload,
   input  logic [smx_pkg::LEN_W-1:0]   program_length,
   output logic                        exec_valid,
   output smx_pkg::rsp_type            exec_result
);
   import smx_pkg::*;

   localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
   localparam int ADDR_W = $clog2(STACK_DEPTH);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(STACK_DEPTH);
   localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);
   localparam logic [CNT_W-1:0] CNT_TWO  = CNT_W'(2);

   // Issue stage state.
   logic [CNT_W-1:0]  cnt_ff, cnt_in, cnt_next;
   logic [CNT_W-1:0]  cnt_m1, cnt_m2;
   logic              has1, has2, full;
   act_type           act_ff, act_in;
   logic              ovf_ff, ovf_in;
   logic              wen_ff, wen_in;
   logic [ADDR_W-1:0] waddr_ff, waddr_in;
   logic [ADDR_W-1:0] rd_addr;
   logic [WORD_W-1:0] imm_ff, rdv_ff;
   logic              ex_valid_ff;
   logic              fwd_hit_ff, fwd_hit_in;
   logic [WORD_W-1:0] fwd_data_ff;

   // Execute stage state.
   logic [WORD_W-1:0] top_ff, top_in;
   logic [WORD_W-1:0] pc_ff, pc_next;
   logic [WORD_W-1:0] ram_rd_data, second, prod;
   logic [CNT_W+DEPTH_W-1:0] cnt_ext;

   assign cnt_m1  = cnt_ff - CNT_ONE;
   assign cnt_m2  = cnt_ff - CNT_TWO;
   assign has1    = (cnt_ff != '0);
   assign has2    = (cnt_ff >= CNT_TWO);
   assign full    = (cnt_ff == CNT_FULL);
   assign rd_addr = cnt_m2[ADDR_W-1:0];

   // Decode: the depth change depends only on the opcode and the current depth.
   always_comb begin
      act_in   = ACT_NONE;
      ovf_in   = 1'b0;
      wen_in   = 1'b0;
      waddr_in = cnt_m1[ADDR_W-1:0];
      cnt_next = cnt_ff;
      case (req_payload.kind)
         OP_PUSH, OP_READ: begin
            if (full) begin
               ovf_in = 1'b1;
            end else begin
               act_in   = (req_payload.kind == OP_PUSH) ? ACT_PUSH_IMM : ACT_PUSH_RD;
               wen_in   = has1;
               cnt_next = cnt_ff + CNT_ONE;
            end
         end
         OP_POP: begin
            if (has1) begin
               act_in   = ACT_POP;
               cnt_next = cnt_m1;
            end
         end
         OP_WRITE: begin
            if (has1) begin
               act_in   = ACT_WRITE;
               cnt_next = cnt_m1;
            end
         end
         OP_JUMPIF: begin
            if (has1) begin
               act_in   = ACT_JUMP;
               cnt_next = cnt_m1;
            end
         end
         OP_ADD, OP_MUL: begin
            if (has2) begin
               act_in   = (req_payload.kind == OP_ADD) ? ACT_ADD : ACT_MUL;
               cnt_next = cnt_m1;
            end
         end
         OP_DUP: begin
            if (has1) begin
               if (full) begin
                  ovf_in = 1'b1;
               end else begin
                  act_in   = ACT_DUP;
                  wen_in   = 1'b1;
                  cnt_next = cnt_ff + CNT_ONE;
               end
            end
         end
         OP_SWAP: begin
            if (has2) begin
               act_in   = ACT_SWAP;
               wen_in   = 1'b1;
               waddr_in = cnt_m2[ADDR_W-1:0];
            end
         end
         OP_OVER: begin
            if (has2) begin
               if (full) begin
                  ovf_in = 1'b1;
               end else begin
                  act_in   = ACT_OVER;
                  wen_in   = 1'b1;
                  cnt_next = cnt_ff + CNT_ONE;
               end
            end
         end
         default: begin
         end
      endcase
   end

   assign cnt_in = req_fire ? cnt_next : cnt_ff;

   // The execute stage writes the old top to the RAM in the same cycle as this read.
   assign fwd_hit_in = wen_ff && (waddr_ff == rd_addr);

   // Issue stage registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff      <= '0;
         ex_valid_ff <= 1'b0;
         wen_ff      <= 1'b0;
         fwd_hit_ff  <= 1'b0;
      end else begin
         cnt_ff      <= cnt_in;
         ex_valid_ff <= req_fire;
         wen_ff      <= req_fire && wen_in;
         fwd_hit_ff  <= fwd_hit_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff      <= act_in;
      ovf_ff      <= ovf_in;
      waddr_ff    <= waddr_in;
      imm_ff      <= req_payload.immediate;
      rdv_ff      <= req_payload.read_value;
      fwd_data_ff <= top_ff;
   end

   // Stack entries below the top.
   smx_ram #(
      .WIDTH (WORD_W),
      .DEPTH (STACK_DEPTH)
   ) u_stack_ram (
      .clock   (clock),
      .wr_en   (wen_ff),
      .wr_addr (waddr_ff),
      .wr_data (top_ff),
      .rd_addr (rd_addr),
      .rd_data (ram_rd_data)
   );

   // Second entry from the RAM, or the value written over it in the previous cycle.
   assign second = fwd_hit_ff ? fwd_data_ff : ram_rd_data;
   assign prod   = top_ff * second;

   // New top of stack.
   always_comb begin
      case (act_ff)
         ACT_PUSH_IMM: top_in = imm_ff;
         ACT_PUSH_RD:  top_in = rdv_ff;
         ACT_ADD:      top_in = top_ff + second;
         ACT_MUL:      top_in = prod;
         ACT_POP,
         ACT_WRITE,
         ACT_JUMP,
         ACT_SWAP,
         ACT_OVER:     top_in = second;
         default:      top_in = top_ff;
      endcase
   end

   // A taken jump needs a non-negative top entry.
   assign pc_next = ((act_ff == ACT_JUMP) && !top_ff[WORD_W-1]) ? imm_ff
                                                                : pc_ff + 32'd1;

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= '0;
      end else if (ex_valid_ff) begin
         pc_ff <= pc_next;
      end
   end

   always_ff @(posedge clock) begin
      if (ex_valid_ff) begin
         top_ff <= top_in;
      end
   end

   // Result of the instruction in execute; the depth counter already holds its new value.
   assign cnt_ext = {{DEPTH_W{1'b0}}, cnt_ff};

   always_comb begin
      exec_result.next_pc       = pc_next;
      exec_result.halted        = pc_next[WORD_W-1] ||
                                  (pc_next >= {{(WORD_W-LEN_W){1'b0}}, program_length});
      exec_result.write_valid   = (act_ff == ACT_WRITE);
      exec_result.write_value   = (act_ff == ACT_WRITE) ? top_ff : '0;
      exec_result.overflow_flag = ovf_ff;
      exec_result.stack_depth   = cnt_ext[DEPTH_W-1:0];
   end

   assign exec_valid = ex_valid_ff;

   // Checks on the stack bookkeeping.
   a_depth_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_FULL)
      else $error("stack depth beyond capacity");

   a_exec_follows_accept: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> ex_valid_ff)
      else $error("accepted request not executed in the next cycle");

   a_write_in_exec: assert property (@(posedge clock) disable iff (reset)
      wen_ff |-> ex_valid_ff)
      else $error("stack RAM written outside execute");

   a_ovf_when_full: assert property (@(posedge clock) disable iff (reset)
      (ex_valid_ff && ovf_ff) |-> (cnt_ff == CNT_FULL))
      else $error("overflow reported on a stack that is not full");

endmodule

@@ rtl/smx_rsp_queue.sv @@
// Small response queue that decouples execution from the response handshake.
module smx_rsp_queue (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push,
   input  smx_pkg::rsp_type             push_data,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output smx_pkg::rsp_type             rsp_payload,
   output logic [smx_pkg::QLVL_W-1:0]   level
);
   import smx_pkg::*;

   localparam logic [QPTR_W-1:0] PTR_LAST = QPTR_W'(QUEUE_DEPTH - 1);

   rsp_type            entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QLVL_W-1:0]  level_ff, level_in;
   logic               pop;

   assign pop = rsp_valid && rsp_ready;

   // Pointer and fill level update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      level_in  = level_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + QPTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + QPTR_W'(1);
      end
      if (push && !pop) begin
         level_in = level_ff + QLVL_W'(1);
      end else if (pop && !push) begin
         level_in = level_ff - QLVL_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign rsp_valid   = (level_ff != '0);
   assign rsp_payload = entry_ff[rd_ptr_ff];
   assign level       = level_ff;

endmodule

@@ sim/tb_top.sv @@
// Self-checking testbench for the stack machine executor, with its own instruction predictor.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import smx_pkg::*;

   localparam int STACK_SIZE  = 64;
   localparam int KIND_MAX    = 2**KIND_W - 1;
   localparam int STALL_LIMIT = 1000;
   localparam int LONG_HOLD   = 80;

   typedef enum {MIX_BALANCED, MIX_FILL, MIX_DRAIN} mix_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_type req_payload = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_type rsp_payload;
   logic csr_wr_en = 1'b0;
   logic [LEN_W-1:0] csr_wr_data = '0;

   // Predictor state: data stack, depth, program counter and program length.
   logic [WORD_W-1:0] stack_m [STACK_SIZE];
   int                depth_m = 0;
   logic [WORD_W-1:0] pc_m = '0;
   logic [LEN_W-1:0]  plen_m = '0;

   req_type pending_q [$];
   rsp_type expected_q [$];
   rsp_type want_rsp;
   int      mismatches = 0;
   int      rsp_count = 0;
   int      gap_left = 0;
   int      hold_left = 0;
   int      ready_roll;
   int      idle_cycles = 0;
   logic    no_idle = 1'b0;

   stack_machine_executor #(.STACK_DEPTH(STACK_SIZE)) uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Execute one instruction on the predictor state and return the response it should give.
   function automatic rsp_type execute_instr(input req_type instr);
      rsp_type           res;
      logic [WORD_W-1:0] next_pc;
      logic [WORD_W-1:0] a;
      logic [WORD_W-1:0] b;
      logic              full;
      res     = '0;
      full    = (depth_m >= STACK_SIZE);
      next_pc = pc_m + 32'd1;
      case (instr.kind)
         OP_PUSH, OP_READ: begin
            if (full) begin
               res.overflow_flag = 1'b1;
            end else begin
               stack_m[depth_m] = (instr.kind == OP_PUSH) ? instr.immediate : instr.read_value;
               depth_m++;
            end
         end
         OP_POP: begin
            if (depth_m > 0) depth_m--;
         end
         OP_ADD, OP_MUL: begin
            if (depth_m >= 2) begin
               a = stack_m[depth_m-1];
               b = stack_m[depth_m-2];
               stack_m[depth_m-2] = (instr.kind == OP_ADD) ? a + b : a * b;
               depth_m--;
            end
         end
         OP_WRITE: begin
            if (depth_m > 0) begin
               res.write_valid = 1'b1;
               res.write_value = stack_m[depth_m-1];
               depth_m--;
            end
         end
         OP_DUP: begin
            if (depth_m > 0) begin
               if (full) begin
                  res.overflow_flag = 1'b1;
               end else begin
                  stack_m[depth_m] = stack_m[depth_m-1];
                  depth_m++;
               end
            end
         end
         OP_JUMPIF: begin
            // An empty stack simply falls through to the next instruction.
            if (depth_m > 0) begin
               a = stack_m[depth_m-1];
               depth_m--;
               if (!a[WORD_W-1]) next_pc = instr.immediate;
            end
         end
         OP_SWAP: begin
            if (depth_m >= 2) begin
               a = stack_m[depth_m-1];
               stack_m[depth_m-1] = stack_m[depth_m-2];
               stack_m[depth_m-2] = a;
            end
         end
         OP_OVER: begin
            if (depth_m >= 2) begin
               if (full) begin
                  res.overflow_flag = 1'b1;
               end else begin
                  stack_m[depth_m] = stack_m[depth_m-2];
                  depth_m++;
               end
            end
         end
         default: begin
         end
      endcase
      pc_m            = next_pc;
      res.next_pc     = next_pc;
      res.halted      = next_pc[WORD_W-1] || (next_pc >= {16'd0, plen_m});
      res.stack_depth = depth_m[DEPTH_W-1:0];
      return res;
   endfunction

   // Data words lean towards the corners of the 32-bit range.
   function automatic logic [WORD_W-1:0] rand_word();
      case ($urandom_range(0, 9))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2: return 32'h0000_0000;
         3: return 32'hFFFF_FFFF;
         4, 5: return $urandom_range(0, 100);
         default: return $urandom;
      endcase
   endfunction

   // Opcode mix: filling mixes grow the stack, draining mixes shrink it.
   function automatic logic [KIND_W-1:0] pick_kind(input mix_type mix);
      int roll;
      roll = $urandom_range(0, 99);
      case (mix)
         MIX_FILL: begin
            if (roll < 40) return OP_PUSH;
            if (roll < 55) return OP_READ;
            if (roll < 70) return OP_DUP;
            if (roll < 85) return OP_OVER;
            if (roll < 90) return OP_SWAP;
            if (roll < 95) return OP_ADD;
         end
         MIX_DRAIN: begin
            if (roll < 25) return OP_POP;
            if (roll < 45) return OP_WRITE;
            if (roll < 60) return OP_JUMPIF;
            if (roll < 70) return OP_ADD;
            if (roll < 80) return OP_MUL;
            if (roll < 85) return OP_SWAP;
            if (roll < 90) return OP_PUSH;
         end
         default: begin
            if (roll < 14) return OP_PUSH;
            if (roll < 20) return OP_POP;
            if (roll < 28) return OP_ADD;
            if (roll < 36) return OP_READ;
            if (roll < 44) return OP_WRITE;
            if (roll < 52) return OP_DUP;
            if (roll < 62) return OP_JUMPIF;
            if (roll < 70) return OP_MUL;
            if (roll < 78) return OP_SWAP;
            if (roll < 86) return OP_OVER;
            if (roll < 90) return OP_PUSH;
         end
      endcase
      return KIND_W'($urandom_range(OP_OVER + 1, KIND_MAX));
   endfunction

   function automatic req_type random_instr(input mix_type mix);
      req_type instr;
      instr.kind       = pick_kind(mix);
      instr.read_value = rand_word();
      // Jump targets mostly land inside the program.
      if (instr.kind == OP_JUMPIF && $urandom_range(0, 9) < 7)
         instr.immediate = $urandom_range(0, plen_m);
      else
         instr.immediate = rand_word();
      return instr;
   endfunction

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (no_idle || roll < 60) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   task automatic queue_instr(input logic [KIND_W-1:0] kind, input logic [WORD_W-1:0] imm,
                              input logic [WORD_W-1:0] rd);
      req_type instr;
      instr     = '{kind: kind, immediate: imm, read_value: rd};
      pending_q = {pending_q, instr};
   endtask

   task automatic queue_random(input mix_type mix, input int count);
      repeat (count) pending_q = {pending_q, random_instr(mix)};
   endtask

   // Wait until every request has been taken and every response has come back.
   task automatic wait_drained();
      while (pending_q.size() != 0 || expected_q.size() != 0 || req_valid)
         @(negedge clock);
      repeat (3) @(negedge clock);
   endtask

   task automatic write_length(input logic [LEN_W-1:0] value);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      plen_m = value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(negedge clock);
   endtask

   task automatic check_field(input string field, input logic [WORD_W-1:0] want,
                              input logic [WORD_W-1:0] got);
      if (got !== want) begin
         mismatches++;
         $display("%0t: %s expected %h actual %h", $time, field, want, got);
      end
   endtask

   // Request driver: predicts each request as it is accepted, then offers the next one.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            expected_q = {expected_q, execute_instr(req_payload)};
            void'(pending_q.pop_front());
            gap_left = pick_gap();
         end
         if (req_valid && !req_ready) begin
            // Hold the request until it is taken.
         end else if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (pending_q.size() != 0) begin
            req_valid   <= 1'b1;
            req_payload <= pending_q[0];
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Response monitor and receiver back-pressure.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_q.size() == 0) begin
               mismatches++;
               $display("%0t: response with none expected, actual %h", $time, rsp_payload);
            end else begin
               want_rsp = expected_q.pop_front();
               check_field("next_pc", want_rsp.next_pc, rsp_payload.next_pc);
               check_field("halted", want_rsp.halted, rsp_payload.halted);
               check_field("write_valid", want_rsp.write_valid, rsp_payload.write_valid);
               check_field("write_value", want_rsp.write_value, rsp_payload.write_value);
               check_field("overflow_flag", want_rsp.overflow_flag, rsp_payload.overflow_flag);
               check_field("stack_depth", want_rsp.stack_depth, rsp_payload.stack_depth);
            end
            rsp_count++;
            // Twice in the run the receiver stalls long enough for the block to back up.
            if (rsp_count == 60 || rsp_count == 350) hold_left = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (no_idle) begin
            rsp_ready <= 1'b1;
         end else begin
            ready_roll = $urandom_range(0, 99);
            if (ready_roll < 70) begin
               rsp_ready <= 1'b1;
            end else begin
               rsp_ready <= 1'b0;
               hold_left = (ready_roll < 95) ? $urandom_range(0, 2) : $urandom_range(8, 30);
            end
         end
      end
   end

   // Watchdog on cycles with no handshake on either channel.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("%0t: no handshake for %0d cycles", $time, idle_cycles);
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // Stimulus phases, each under its own program length.
   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      write_length(16'hFFFF);
      // Missing operands on an empty stack and a jump with nothing to test.
      queue_instr(OP_POP, 32'd0, 32'd0);
      queue_instr(OP_WRITE, 32'd0, 32'd0);
      queue_instr(OP_DUP, 32'd0, 32'd0);
      queue_instr(OP_ADD, 32'd0, 32'd0);
      queue_instr(OP_JUMPIF, 32'd5, 32'd0);
      // One entry only: two-operand instructions leave it alone.
      queue_instr(OP_PUSH, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
      queue_instr(OP_SWAP, 32'd0, 32'd0);
      queue_instr(OP_OVER, 32'd0, 32'd0);
      queue_instr(OP_MUL, 32'd0, 32'd0);
      // Wrapping arithmetic at the extremes of the word.
      queue_instr(OP_READ, 32'hFFFF_FFFF, 32'h8000_0000);
      queue_instr(OP_ADD, 32'd0, 32'd0);
      queue_instr(OP_PUSH, 32'hFFFF_FFFF, 32'd0);
      queue_instr(OP_MUL, 32'd0, 32'd0);
      queue_instr(OP_DUP, 32'd0, 32'd0);
      queue_instr(OP_OVER, 32'd0, 32'd0);
      queue_instr(OP_SWAP, 32'd0, 32'd0);
      queue_instr(OP_WRITE, 32'd0, 32'd0);
      // Jumps taken, not taken, and to targets outside the program.
      queue_instr(OP_JUMPIF, 32'd40, 32'd0);
      queue_instr(OP_PUSH, 32'h8000_0000, 32'd0);
      queue_instr(OP_JUMPIF, 32'd3, 32'd0);
      queue_instr(OP_PUSH, 32'd0, 32'd0);
      queue_instr(OP_JUMPIF, 32'h7FFF_FFFF, 32'd0);
      // Unused opcodes just advance; the counter wraps to negative here.
      queue_instr(KIND_W'(OP_OVER + 1), 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      queue_instr(KIND_W'(KIND_MAX), 32'd0, 32'd0);
      queue_instr(OP_PUSH, 32'd5, 32'd0);
      queue_instr(OP_JUMPIF, 32'hFFFF_FFF9, 32'd0);
      queue_instr(OP_PUSH, 32'd1, 32'd0);
      queue_instr(OP_JUMPIF, 32'd2, 32'd0);
      queue_random(MIX_BALANCED, 100);
      wait_drained();

      // Zero length: everything reports halted; fill the stack past full, then shrink it again.
      write_length(16'd0);
      queue_random(MIX_FILL, 120);
      queue_random(MIX_DRAIN, 60);
      wait_drained();

      // Random length, then a run with no gaps between requests and the receiver always ready.
      write_length($urandom_range(1, 65534));
      queue_random(MIX_BALANCED, 60);
      queue_random(MIX_FILL, 30);
      queue_random(MIX_DRAIN, 30);
      wait_drained();
      no_idle = 1'b1;
      queue_random(MIX_BALANCED, 120);
      wait_drained();
      no_idle = 1'b0;

      // Short program so jumps land both inside and beyond it.
      write_length(16'd20);
      queue_random(MIX_BALANCED, 120);
      wait_drained();

      if (expected_q.size() != 0) mismatches++;
      if (mismatches == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
